FILE: hdl/qrv_pkg.sv
`default_nettype none
package qrv_pkg;
  localparam int COMP_W = 16;
  localparam int N_W    = 33;
  localparam int NUM_W  = 53;
  localparam int A_W    = 54;
  localparam int D_W    = N_W + 1;
  localparam int QB     = 17;
  localparam int DIV_LAT = 3 + QB;
  localparam int FRONT_LAT = 4;
  localparam logic signed [COMP_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [COMP_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          ovf;
    logic          neg;
  } qrv_quot_t;
endpackage
`default_nettype wire

FILE: hdl/qrv_div.sv
`default_nettype none
module qrv_div
  import qrv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [N_W-1:0]          n,
  output qrv_quot_t                    quot
);
  // prep: magnitude, then dividend 2|num|+n and divisor 2n
  logic [A_W-1:0] mag;
  logic           neg0;
  logic [N_W-1:0] n0;
  logic [A_W-1:0] a1;
  logic [D_W-1:0] d1;
  logic           neg1;
  logic [A_W-1:0] rem  [0:QB];
  logic [QB-1:0]  qacc [0:QB];
  logic [D_W-1:0] dd   [0:QB];
  logic           ovf  [0:QB];
  logic           sgn  [0:QB];
  logic signed [NUM_W-1:0] absn;

  assign absn = num[NUM_W-1] ? -num : num;

  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= A_W'($unsigned(absn));
      neg0 <= num[NUM_W-1];
      n0   <= n;
      a1   <= (mag << 1) + A_W'(n0);
      d1   <= {n0, 1'b0};
      neg1 <= neg0;
      rem[0]  <= a1;
      qacc[0] <= '0;
      dd[0]   <= d1;
      ovf[0]  <= a1 >= (A_W'(d1) << QB);
      sgn[0]  <= neg1;
    end
  end

  // one restoring step per stage, quotient MSB first
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [A_W-1:0] sh;
    logic           take;
    assign sh   = A_W'(dd[k]) << (QB - 1 - k);
    assign take = rem[k] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - sh : rem[k];
        qacc[k+1] <= qacc[k] | (QB'(take) << (QB - 1 - k));
        dd[k+1]   <= dd[k];
        ovf[k+1]  <= ovf[k];
        sgn[k+1]  <= sgn[k];
      end
    end
  end

  assign quot.q   = qacc[QB];
  assign quot.ovf = ovf[QB];
  assign quot.neg = sgn[QB];
endmodule
`default_nettype wire

FILE: hdl/quaternion_rotate_vector.sv
// Quaternion vector rotation: r = q * v * q^-1 for a quaternion q that need
// not be normalized, with the inverse taken as conjugate over squared length.
// Input channel s_*: one transaction carries quat_x/y/z/w (any common scale)
// and vec_x/y/z (Q7.8). Output channel m_*: rot_x/y/z (Q7.8, rounded to
// nearest with halves away from zero, saturated) plus flags zero_quat and
// clipped in tuser.
// A transaction passes from input to m_tvalid through four arithmetic stages
// (products, sums, products, numerator sum), three divider setup stages,
// seventeen restoring divider stages (one quotient bit each, set by the
// 54-bit subtract-compare) and the output register. Throughput is one
// transaction per cycle while the output is not stalled.
// The whole pipeline advances together; when the output holds a result that
// is not taken, every stage holds and s_tready drops, so nothing is lost or
// repeated. Reset clears the valid bits and the output valid; data registers
// are not reset. A zero quaternion yields a zero vector with zero_quat set.
`default_nettype none
module quaternion_rotate_vector
  import qrv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (16 bits each)
  input  wire logic [111:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // rot_x, rot_y, rot_z (16 bits each)
  output logic [47:0]       m_tdata,
  // zero_quat, clipped
  output logic [1:0]        m_tuser
);
  localparam int TOTAL = FRONT_LAT + DIV_LAT;

  logic en;
  logic [TOTAL-1:0] vld;
  logic [DIV_LAT+FRONT_LAT-3:0] zpipe;

  // advance whenever the output register is free or being emptied
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [COMP_W-1:0] qx, qy, qz, qw, vx, vy, vz;
  assign qx = s_tdata[15:0];
  assign qy = s_tdata[31:16];
  assign qz = s_tdata[47:32];
  assign qw = s_tdata[63:48];
  assign vx = s_tdata[79:64];
  assign vy = s_tdata[95:80];
  assign vz = s_tdata[111:96];

  // stage 1: products of inputs
  logic signed [31:0] sxx, syy, szz, sww, dx, dy, dz;
  logic signed [31:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [COMP_W-1:0] q1x, q1y, q1z, q1w, v1x, v1y, v1z;
  // stage 2: sums
  logic [N_W-1:0] n2;
  logic signed [33:0] s2, dot2;
  logic signed [32:0] cx2, cy2, cz2;
  logic signed [COMP_W-1:0] q2x, q2y, q2z, q2w, v2x, v2y, v2z;
  // stage 3: second products
  logic signed [49:0] ps_x, ps_y, ps_z, pd_x, pd_y, pd_z;
  logic signed [48:0] pc_x, pc_y, pc_z;
  logic [N_W-1:0] n3;
  // stage 4: numerators
  logic signed [NUM_W-1:0] num_x, num_y, num_z;
  logic [N_W-1:0] n4;

  always_ff @(posedge clk) begin
    if (en) begin
      sxx <= qx * qx;  syy <= qy * qy;  szz <= qz * qz;  sww <= qw * qw;
      dx  <= qx * vx;  dy  <= qy * vy;  dz  <= qz * vz;
      p_yz <= qy * vz; p_zy <= qz * vy;
      p_zx <= qz * vx; p_xz <= qx * vz;
      p_xy <= qx * vy; p_yx <= qy * vx;
      q1x <= qx; q1y <= qy; q1z <= qz; q1w <= qw;
      v1x <= vx; v1y <= vy; v1z <= vz;

      n2   <= N_W'($unsigned(34'(sxx) + 34'(syy) + 34'(szz) + 34'(sww)));
      s2   <= 34'(sww) - 34'(sxx) - 34'(syy) - 34'(szz);
      dot2 <= 34'(dx) + 34'(dy) + 34'(dz);
      cx2  <= 33'(p_yz) - 33'(p_zy);
      cy2  <= 33'(p_zx) - 33'(p_xz);
      cz2  <= 33'(p_xy) - 33'(p_yx);
      q2x <= q1x; q2y <= q1y; q2z <= q1z; q2w <= q1w;
      v2x <= v1x; v2y <= v1y; v2z <= v1z;

      ps_x <= s2 * v2x;   ps_y <= s2 * v2y;   ps_z <= s2 * v2z;
      pd_x <= dot2 * q2x; pd_y <= dot2 * q2y; pd_z <= dot2 * q2z;
      pc_x <= cx2 * q2w;  pc_y <= cy2 * q2w;  pc_z <= cz2 * q2w;
      n3 <= n2;

      num_x <= NUM_W'(ps_x) + (NUM_W'(pd_x) <<< 1) + (NUM_W'(pc_x) <<< 1);
      num_y <= NUM_W'(ps_y) + (NUM_W'(pd_y) <<< 1) + (NUM_W'(pc_y) <<< 1);
      num_z <= NUM_W'(ps_z) + (NUM_W'(pd_z) <<< 1) + (NUM_W'(pc_z) <<< 1);
      n4 <= n3;
    end
  end

  // zero-length flag rides from stage 2 to the divider output
  always_ff @(posedge clk) begin
    if (en) begin
      zpipe <= {zpipe[$bits(zpipe)-2:0], n2 == '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
    end
  end

  qrv_quot_t quot_x, quot_y, quot_z;

  qrv_div u_div_x (.clk(clk), .en(en), .num(num_x), .n(n4), .quot(quot_x));
  qrv_div u_div_y (.clk(clk), .en(en), .num(num_y), .n(n4), .quot(quot_y));
  qrv_div u_div_z (.clk(clk), .en(en), .num(num_z), .n(n4), .quot(quot_z));

  function automatic logic [COMP_W:0] sat(input qrv_quot_t qq);
    logic big;
    logic [COMP_W-1:0] r;
    big = 1'b0;
    r = '0;
    if (qq.neg) begin
      big = qq.ovf || (qq.q > QB'(32768));
      r = big ? SAT_MIN : COMP_W'(-qq.q);
    end else begin
      big = qq.ovf || (qq.q > QB'(32767));
      r = big ? SAT_MAX : COMP_W'(qq.q);
    end
    return {big, r};
  endfunction

  logic [COMP_W:0] sx, sy, sz;
  logic zq;
  assign sx = sat(quot_x);
  assign sy = sat(quot_y);
  assign sz = sat(quot_z);
  assign zq = zpipe[$bits(zpipe)-1];

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zq) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {sz[COMP_W-1:0], sy[COMP_W-1:0], sx[COMP_W-1:0]};
        m_tuser <= {sx[COMP_W] | sy[COMP_W] | sz[COMP_W], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/qrv_checker.sv
`default_nettype none
module qrv_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [47:0]  m_tdata,
  input wire logic [1:0]   m_tuser
);
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("zero quaternion result not cleared");

  a_clip_ext: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000 ||
      m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8000 ||
      m_tdata[47:32] == 16'h7FFF || m_tdata[47:32] == 16'h8000)
    else $error("clip flag without saturated component");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready not tied to output space");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");
endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
  import qrv_pkg::*;

  typedef struct packed {
    logic signed [15:0] qx, qy, qz, qw, vx, vy, vz;
  } rot_req_t;

  typedef struct packed {
    logic signed [15:0] rx, ry, rz;
    logic               zero_quat;
    logic               clipped;
  } rot_res_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (16 bits each)
  logic [111:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // rot_x, rot_y, rot_z (16 bits each)
  logic [47:0]  m_tdata;
  // zero_quat, clipped
  logic [1:0]   m_tuser;

  quaternion_rotate_vector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  localparam int PIPE_LAT = 25;
  localparam int N_RANDOM = 650;

  // Rotated vectors still owed by the block, oldest first.
  rot_res_t rotated_q[$];
  int       fail_cnt = 0;
  bit       no_idle = 0;     // set for the last stretch of the run
  bit       hold_long = 0;   // request a long receiver hold-off
  bit       src_done = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Divide, round half away from zero, saturate to 16 bits.
  function automatic logic signed [15:0] div_round_sat(
    input logic signed [63:0] num, input logic signed [63:0] den, inout logic clip);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (num < 0) ? -num : num;
    quo = (2 * mag + den) / (2 * den);
    if (num < 0) begin
      if (quo > 64'd32768) begin
        clip = 1'b1;
        return SAT_MIN;
      end
      return -quo[15:0];
    end
    if (quo > 64'd32767) begin
      clip = 1'b1;
      return SAT_MAX;
    end
    return quo[15:0];
  endfunction

  function automatic rot_res_t rotate_vector(input rot_req_t t);
    logic signed [63:0] qx, qy, qz, qw, vx, vy, vz;
    logic signed [63:0] uu, n, s, d2, cx, cy, cz;
    logic               clip;
    rot_res_t           r;
    qx = t.qx; qy = t.qy; qz = t.qz; qw = t.qw;
    vx = t.vx; vy = t.vy; vz = t.vz;
    uu = qx*qx + qy*qy + qz*qz;
    n = uu + qw*qw;
    r = '0;
    if (n == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    clip = 1'b0;
    s = qw*qw - uu;
    d2 = 2 * (qx*vx + qy*vy + qz*vz);
    cx = qy*vz - qz*vy;
    cy = qz*vx - qx*vz;
    cz = qx*vy - qy*vx;
    r.rx = div_round_sat(s*vx + d2*qx + 2*qw*cx, n, clip);
    r.ry = div_round_sat(s*vy + d2*qy + 2*qw*cy, n, clip);
    r.rz = div_round_sat(s*vz + d2*qz + 2*qw*cz, n, clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic logic [111:0] pack_req(input rot_req_t t);
    return {t.vz, t.vy, t.vx, t.qw, t.qz, t.qy, t.qx};
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      3: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one transaction with random leading idle, hold until accepted.
  task automatic send(input rot_req_t t, input bit has_exp, input rot_res_t exp_res);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_req(t);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rotated_q.push_back(has_exp ? exp_res : rotate_vector(t));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // Directed table: expected result typed in where it is obvious.
  typedef struct {
    rot_req_t req;
    bit       has_exp;
    rot_res_t res;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    // zero quaternion gives zero vector and the error flag
    '{'{0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 1}, 1, '{0, 0, 0, 1, 0}},
    '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1, 0}},
    // identity at several scales leaves the vector alone
    '{'{0, 0, 0, 1, 256, -256, 77}, 1, '{256, -256, 77, 0, 0}},
    '{'{0, 0, 0, 16'sh8000, 16'sh7FFF, 16'sh8000, 0}, 1,
      '{16'sh7FFF, 16'sh8000, 0, 0, 0}},
    '{'{0, 0, 0, 16'sh7FFF, -1, 1, 16'sh8000}, 1, '{-1, 1, 16'sh8000, 0, 0}},
    // 180 degrees about z negates x and y
    '{'{0, 0, 5, 0, 100, 200, 300}, 1, '{-100, -200, 300, 0, 0}},
    // 180 about x turns -32768 into +32768: saturates
    '{'{1, 0, 0, 0, 0, 16'sh8000, 0}, 1, '{0, 16'sh7FFF, 0, 0, 1}},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000}, 0, '0},
    '{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 0, '0},
    // 90 degrees about z with unnormalized q, odd values exercise rounding
    '{'{0, 0, 3, 3, 101, 33, -7}, 0, '0},
    '{'{1, 1, 1, 1, 16'sh7FFF, 16'sh7FFF, 0}, 0, '0},
    '{'{1, 2, 3, 4, 1, 1, 1}, 0, '0},
    '{'{-3, 5, -7, 11, 16'sh8000, 16'sh7FFF, 16'sh8000}, 0, '0},
    '{'{0, 1, 0, 1, 3, 0, 0}, 0, '0},
    '{'{16'sh7FFF, 0, 0, 1, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 0, '0}
  };

  // Source process.
  initial begin
    rot_req_t t;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].res);
    // pause until everything has come back
    drain();
    // back the block up behind a long receiver hold-off
    hold_long <= 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 120) no_idle = 1'b1;
      if (i == 300) drain();
      t.qx = rand_comp(); t.qy = rand_comp(); t.qz = rand_comp(); t.qw = rand_comp();
      t.vx = rand_comp(); t.vy = rand_comp(); t.vz = rand_comp();
      if ($urandom_range(0, 30) == 0) {t.qx, t.qy, t.qz, t.qw} = '0;
      send(t, 0, '0);
    end
    s_tvalid <= 1'b0;
    src_done <= 1'b1;
  end

  // Sink ready: random stalls, one long hold-off on request.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
        m_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rot_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0], m_tuser[1]};
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result actual=%p", $time, got);
        fail_cnt++;
      end else begin
        want = rotated_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected=%p actual=%p", $time, want, got);
          fail_cnt++;
        end
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    @(posedge src_done);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (fail_cnt == 0 && rotated_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: quaternion_rotate_vector.f
hdl/qrv_pkg.sv
hdl/qrv_div.sv
hdl/quaternion_rotate_vector.sv
hdl/qrv_checker.sv
verif/tb_top.sv
